// ===== sv/sspc_pkg.sv =====
`timescale 1ns / 1ps

package sspc_pkg;

    localparam int PULSE_BITS      = 12;
    localparam int ANGLE_FRAC_BITS = 4;

    localparam int PULSE_W   = PULSE_BITS;
    localparam int DEG_W     = 10;
    localparam int ANGLE_W   = 14;
    localparam int DIR_W     = 2;
    localparam int REQ_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    localparam int SCL_W   = (ANGLE_W > DEG_W + ANGLE_FRAC_BITS) ? ANGLE_W
                                                                  : DEG_W + ANGLE_FRAC_BITS;
    localparam int X_W     = SCL_W + 1;
    localparam int DEN_W   = DEG_W + 1 + ANGLE_FRAC_BITS;
    localparam int PDIFF_W = PULSE_W + 1;
    localparam int OP_A_W  = (X_W > PULSE_W + 1) ? X_W : PULSE_W + 1;
    localparam int OP_B_W  = (PDIFF_W > DEN_W) ? PDIFF_W : DEN_W;
    localparam int OP_W    = (OP_A_W > OP_B_W) ? OP_A_W : OP_B_W;
    localparam int PROD_W  = 2 * OP_W;
    localparam int NUM_W   = PROD_W + 1;
    localparam int DIV_W   = NUM_W - 1;
    localparam int REM_W   = DEN_W + 1;
    localparam int CNT_W   = $clog2(DIV_W + 1);

    localparam logic signed [DEG_W-1:0] DEG_LOW_RST   = 10'sd0;
    localparam logic signed [DEG_W-1:0] DEG_HIGH_RST  = 10'sd180;
    localparam logic signed [DEG_W-1:0] HOME_DEG_RST  = 10'sd90;
    localparam logic [PULSE_W-1:0]      PLS_LOW_RST   = PULSE_W'(150);
    localparam logic [PULSE_W-1:0]      PLS_HIGH_RST  = PULSE_W'(600);
    localparam logic [PULSE_W-1:0]      STEP_RST      = PULSE_W'(5);
    localparam logic [PULSE_W-1:0]      PULSE_RST     = PULSE_W'(375);

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK   = 3'd0,
        REQ_ABS    = 3'd1,
        REQ_REL    = 3'd2,
        REQ_ROTATE = 3'd3,
        REQ_STOP   = 3'd4,
        REQ_HOME   = 3'd5
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEG_LOW  = 3'd0,
        CFG_DEG_HIGH = 3'd1,
        CFG_PLS_LOW  = 3'd2,
        CFG_PLS_HIGH = 3'd3,
        CFG_STEP     = 3'd4,
        CFG_HOME_DEG = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_NUM,
        ST_MUL_OFS,
        ST_PREP,
        ST_DIV,
        ST_POST,
        ST_OUT
    } t_state;

endpackage

// ===== sv/servo_slew_position_controller.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                    payload
// in        input      i_in_valid / o_in_stall      i_req_type, i_angle, i_direction
// out       output     o_out_valid / i_out_stall    o_pulse_width, o_target_width, o_pwm_write
// cfg       input      i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// tick, rotate, stop, unused requests and mapped requests with equal degree bounds:
// result in the cycle after the transfer
// absolute, relative and home: result after ST_MUL_NUM, ST_MUL_OFS, ST_PREP, ST_DIV and
// ST_POST; ST_DIV is the restoring divider that produces one quotient bit per cycle
// one item at a time; o_in_stall is high from transfer until the result is taken
// synchronous active-low reset restores the configuration registers, the state and a pulse of 375

module servo_slew_position_controller
    import sspc_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [REQ_W-1:0]            i_req_type,
    input  logic signed [ANGLE_W-1:0]   i_angle,
    input  logic signed [DIR_W-1:0]     i_direction,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [PULSE_W-1:0]          o_pulse_width,
    output logic [PULSE_W-1:0]          o_target_width,
    output logic                        o_pwm_write,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DAT_W-1:0]        i_cfg_data
);

    t_state                       r_state, n_state;
    logic signed [DEG_W-1:0]      r_deg_low, r_deg_high, r_home;
    logic [PULSE_W-1:0]           r_pls_low, r_pls_high, r_step;
    logic [PULSE_W-1:0]           r_cur, n_cur, r_tgt, n_tgt;
    logic                         r_wr, n_wr;
    logic                         r_rel, n_rel;
    logic signed [X_W-1:0]        r_x, n_x;
    logic signed [DEN_W-1:0]      r_den, n_den;
    logic signed [NUM_W-1:0]      r_num, n_num, r_prod, n_prod;
    logic                         r_neg, n_neg;
    logic [REM_W-1:0]             r_rem, n_rem;
    logic [DIV_W-1:0]             r_quo, n_quo;
    logic [CNT_W-1:0]             r_cnt, n_cnt;

    logic                         deg_ok;
    logic signed [X_W-1:0]        ang_x, dl_x, hd_x;
    logic signed [DEN_W-1:0]      den_c;
    logic signed [PDIFF_W-1:0]    pdiff;
    logic signed [OP_W-1:0]       mul_a, mul_b;
    logic signed [PROD_W-1:0]     mul_p;
    logic signed [NUM_W-1:0]      sum, q_s, pl_s, ph_s, clamp_lo, rel_s;
    logic [REM_W-1:0]             trial;
    logic signed [PULSE_W:0]      diff;
    logic [PULSE_W-1:0]           mag;

    assign o_cfg_ready    = 1'b1;
    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = (r_state == ST_OUT);
    assign o_pulse_width  = r_cur;
    assign o_target_width = r_tgt;
    assign o_pwm_write    = r_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg_low  <= DEG_LOW_RST;
            r_deg_high <= DEG_HIGH_RST;
            r_pls_low  <= PLS_LOW_RST;
            r_pls_high <= PLS_HIGH_RST;
            r_step     <= STEP_RST;
            r_home     <= HOME_DEG_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEG_LOW:  r_deg_low  <= $signed(i_cfg_data[DEG_W-1:0]);
                CFG_DEG_HIGH: r_deg_high <= $signed(i_cfg_data[DEG_W-1:0]);
                CFG_PLS_LOW:  r_pls_low  <= i_cfg_data[PULSE_W-1:0];
                CFG_PLS_HIGH: r_pls_high <= i_cfg_data[PULSE_W-1:0];
                CFG_STEP:     r_step     <= i_cfg_data[PULSE_W-1:0];
                CFG_HOME_DEG: r_home     <= $signed(i_cfg_data[DEG_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cur   <= PULSE_RST;
            r_tgt   <= PULSE_RST;
            r_wr    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_tgt   <= n_tgt;
            r_wr    <= n_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rel  <= n_rel;
        r_x    <= n_x;
        r_den  <= n_den;
        r_num  <= n_num;
        r_prod <= n_prod;
        r_neg  <= n_neg;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
    end

    // shared multiplier
    always_comb begin
        if (r_state == ST_MUL_NUM) begin
            mul_a = OP_W'(r_x);
            mul_b = OP_W'(pdiff);
        end else begin
            mul_a = $signed(OP_W'(r_pls_low));
            mul_b = OP_W'(r_den);
        end
    end
    assign mul_p = mul_a * mul_b;

    assign deg_ok = (r_deg_high != r_deg_low);
    assign ang_x  = X_W'(i_angle);
    assign dl_x   = X_W'(r_deg_low) <<< ANGLE_FRAC_BITS;
    assign hd_x   = X_W'(r_home) <<< ANGLE_FRAC_BITS;
    assign den_c  = (DEN_W'(r_deg_high) - DEN_W'(r_deg_low)) <<< ANGLE_FRAC_BITS;
    assign pdiff  = $signed({1'b0, r_pls_high}) - $signed({1'b0, r_pls_low});

    assign sum    = r_num + r_prod;
    assign trial  = {r_rem[REM_W-2:0], r_quo[DIV_W-1]};
    assign q_s    = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign pl_s   = $signed(NUM_W'(r_pls_low));
    assign ph_s   = $signed(NUM_W'(r_pls_high));
    assign clamp_lo = (q_s < pl_s) ? pl_s : q_s;
    assign rel_s  = q_s + $signed(NUM_W'(r_tgt));

    assign diff   = $signed({1'b0, r_tgt}) - $signed({1'b0, r_cur});
    assign mag    = diff[PULSE_W] ? PULSE_W'(-diff) : diff[PULSE_W-1:0];

    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        n_tgt   = r_tgt;
        n_wr    = r_wr;
        n_rel   = r_rel;
        n_x     = r_x;
        n_den   = r_den;
        n_num   = r_num;
        n_prod  = r_prod;
        n_neg   = r_neg;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_wr    = 1'b0;
                    n_state = ST_OUT;
                    n_den   = den_c;
                    case (t_req'(i_req_type))
                        REQ_TICK: begin
                            n_wr = 1'b1;
                            if (mag <= r_step) begin
                                n_cur = r_tgt;
                            end else if (!diff[PULSE_W]) begin
                                n_cur = r_cur + r_step;
                            end else begin
                                n_cur = r_cur - r_step;
                            end
                        end
                        REQ_ABS: begin
                            n_rel = 1'b0;
                            n_x   = ang_x - dl_x;
                            if (deg_ok) begin
                                n_state = ST_MUL_NUM;
                            end
                        end
                        REQ_REL: begin
                            n_rel = 1'b1;
                            n_x   = ang_x;
                            if (deg_ok) begin
                                n_state = ST_MUL_NUM;
                            end
                        end
                        REQ_HOME: begin
                            n_rel = 1'b0;
                            n_x   = hd_x - dl_x;
                            if (deg_ok) begin
                                n_state = ST_MUL_NUM;
                            end
                        end
                        REQ_ROTATE: begin
                            if (i_direction[DIR_W-1]) begin
                                n_tgt = r_pls_low;
                            end else if (i_direction != '0) begin
                                n_tgt = r_pls_high;
                            end else begin
                                n_tgt = r_cur;
                            end
                        end
                        REQ_STOP: begin
                            n_tgt = r_cur;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL_NUM: begin
                // fold the divisor sign into the numerator
                if (r_den < 0) begin
                    n_num = -NUM_W'(mul_p);
                    n_den = -r_den;
                end else begin
                    n_num = NUM_W'(mul_p);
                end
                n_state = ST_MUL_OFS;
            end
            ST_MUL_OFS: begin
                n_prod  = r_rel ? '0 : NUM_W'(mul_p);
                n_state = ST_PREP;
            end
            ST_PREP: begin
                n_neg   = sum < 0;
                n_quo   = sum < 0 ? DIV_W'(-sum) : DIV_W'(sum);
                n_rem   = '0;
                n_cnt   = CNT_W'(DIV_W);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (trial >= {1'b0, r_den}) begin
                    n_rem = trial - {1'b0, r_den};
                    n_quo = {r_quo[DIV_W-2:0], 1'b1};
                end else begin
                    n_rem = trial;
                    n_quo = {r_quo[DIV_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_POST;
                end
            end
            ST_POST: begin
                if (r_rel) begin
                    if (rel_s < 0) begin
                        n_tgt = '0;
                    end else if (rel_s > $signed(NUM_W'({PULSE_W{1'b1}}))) begin
                        n_tgt = '1;
                    end else begin
                        n_tgt = rel_s[PULSE_W-1:0];
                    end
                end else begin
                    n_tgt = (clamp_lo > ph_s) ? r_pls_high : clamp_lo[PULSE_W-1:0];
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import sspc_pkg::*;

    localparam logic [REQ_W-1:0]        REQ_SPARE_A  = 3'd6;
    localparam logic [REQ_W-1:0]        REQ_SPARE_B  = 3'd7;
    localparam logic signed [DIR_W-1:0] DIR_UP       = 2'b01;
    localparam logic signed [DIR_W-1:0] DIR_HOLD     = 2'b00;
    localparam logic signed [DIR_W-1:0] DIR_DOWN     = 2'b11;
    localparam logic signed [DIR_W-1:0] DIR_FAR_DOWN = 2'b10;
    localparam int     ANGLE_MAX   = 5760;
    localparam longint ANGLE_SCALE = longint'(1) << ANGLE_FRAC_BITS;
    localparam longint PULSE_TOP   = (longint'(1) << PULSE_BITS) - 1;

    typedef struct {
        logic [REQ_W-1:0]          req;
        logic signed [ANGLE_W-1:0] angle;
        logic signed [DIR_W-1:0]   dir;
        bit                        drain;
    } servo_cmd_t;

    typedef struct {
        logic [PULSE_W-1:0] pulse;
        logic [PULSE_W-1:0] target;
        logic               pwm;
    } servo_out_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [REQ_W-1:0]          i_req_type = '0;
    logic signed [ANGLE_W-1:0] i_angle = '0;
    logic signed [DIR_W-1:0]   i_direction = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [PULSE_W-1:0]        o_pulse_width;
    logic [PULSE_W-1:0]        o_target_width;
    logic                      o_pwm_write;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]      i_cfg_data = '0;

    servo_slew_position_controller i_dut (.*);

    // register copies and servo state as the predictor sees them
    logic signed [DEG_W-1:0] deg_lo_r, deg_hi_r, home_deg_r;
    logic [PULSE_W-1:0]      pls_lo_r, pls_hi_r, step_r;
    logic [PULSE_W-1:0]      cur_pulse, tgt_pulse;

    servo_cmd_t pending_cmds[$];
    servo_out_t pending_widths[$];
    servo_cmd_t drv_cmd, seen_cmd;
    servo_out_t want;
    int         errors = 0;
    int         burst_left = 1;
    int         gap_left = 0;
    int         stall_mode = 0;
    int         stall_left = 0;

    function automatic longint clamp_pulse(longint v);
        if (v < 0) return 0;
        if (v > PULSE_TOP) return PULSE_TOP;
        return v;
    endfunction

    function automatic longint angle_to_pulse(longint a);
        longint num, den, p;
        num = (a - longint'(deg_lo_r) * ANGLE_SCALE) * (longint'(pls_hi_r) - longint'(pls_lo_r));
        den = (longint'(deg_hi_r) - longint'(deg_lo_r)) * ANGLE_SCALE;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        p = (num + longint'(pls_lo_r) * den) / den;
        if (p < longint'(pls_lo_r)) p = longint'(pls_lo_r);
        if (p > longint'(pls_hi_r)) p = longint'(pls_hi_r);
        return clamp_pulse(p);
    endfunction

    function automatic void reset_servo_model();
        deg_lo_r   = DEG_LOW_RST;
        deg_hi_r   = DEG_HIGH_RST;
        home_deg_r = HOME_DEG_RST;
        pls_lo_r   = PLS_LOW_RST;
        pls_hi_r   = PLS_HIGH_RST;
        step_r     = STEP_RST;
        cur_pulse  = PULSE_W'(angle_to_pulse(longint'(home_deg_r) * ANGLE_SCALE));
        tgt_pulse  = cur_pulse;
    endfunction

    function automatic servo_out_t step_servo(servo_cmd_t c);
        servo_out_t r;
        longint     a, cur, tgt, diff, mag, den;
        bit         span_ok;
        a       = longint'(c.angle);
        cur     = longint'(cur_pulse);
        tgt     = longint'(tgt_pulse);
        span_ok = (deg_hi_r != deg_lo_r);
        r.pwm   = 1'b0;
        case (c.req)
            REQ_TICK: begin
                diff = tgt - cur;
                mag  = (diff < 0) ? -diff : diff;
                if (mag <= longint'(step_r)) cur = tgt;
                else if (diff > 0) cur = cur + longint'(step_r);
                else cur = cur - longint'(step_r);
                cur   = clamp_pulse(cur);
                r.pwm = 1'b1;
            end
            REQ_ABS: begin
                if (span_ok) tgt = angle_to_pulse(a);
            end
            REQ_REL: begin
                if (span_ok) begin
                    den = (longint'(deg_hi_r) - longint'(deg_lo_r)) * ANGLE_SCALE;
                    tgt = clamp_pulse(tgt + (a * (longint'(pls_hi_r) - longint'(pls_lo_r))) / den);
                end
            end
            REQ_ROTATE: begin
                if (c.dir > 0) tgt = longint'(pls_hi_r);
                else if (c.dir < 0) tgt = longint'(pls_lo_r);
                else tgt = cur;
            end
            REQ_STOP: tgt = cur;
            REQ_HOME: begin
                if (span_ok) tgt = angle_to_pulse(longint'(home_deg_r) * ANGLE_SCALE);
            end
            default: ;
        endcase
        cur_pulse = PULSE_W'(cur);
        tgt_pulse = PULSE_W'(tgt);
        r.pulse   = cur_pulse;
        r.target  = tgt_pulse;
        return r;
    endfunction

    function automatic servo_cmd_t make_cmd(logic [REQ_W-1:0] req, int angle,
                                            logic signed [DIR_W-1:0] dir);
        servo_cmd_t c;
        c.req   = req;
        c.angle = ANGLE_W'(angle);
        c.dir   = dir;
        c.drain = 1'b0;
        return c;
    endfunction

    function automatic servo_cmd_t random_cmd();
        servo_cmd_t c;
        int         pick, lo, hi, dl, dh;
        pick    = $urandom_range(0, 99);
        c.angle = ANGLE_W'(int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX);
        c.dir   = DIR_W'($urandom_range(0, 3));
        c.drain = ($urandom_range(0, 59) == 0);
        if (pick < 40) begin
            c.req = REQ_TICK;
        end else if (pick < 58) begin
            c.req = REQ_ABS;
            if ($urandom_range(0, 1) == 1) begin
                dl = deg_lo_r;
                dh = deg_hi_r;
                lo = ((dl < dh) ? dl : dh) * 16;
                hi = ((dl < dh) ? dh : dl) * 16;
                if (lo < -ANGLE_MAX) lo = -ANGLE_MAX;
                if (hi > ANGLE_MAX) hi = ANGLE_MAX;
                c.angle = ANGLE_W'(lo + int'($urandom_range(0, hi - lo)));
            end
        end else if (pick < 70) begin
            c.req = REQ_REL;
            if ($urandom_range(0, 1) == 1) c.angle = ANGLE_W'(int'($urandom_range(0, 400)) - 200);
        end else if (pick < 80) begin
            c.req = REQ_ROTATE;
        end else if (pick < 86) begin
            c.req = REQ_STOP;
        end else if (pick < 94) begin
            c.req = REQ_HOME;
        end else if (pick < 97) begin
            c.req = REQ_SPARE_A;
        end else begin
            c.req = REQ_SPARE_B;
        end
        return c;
    endfunction

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || i_in_valid || pending_widths.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_DAT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DEG_LOW:  deg_lo_r = data[DEG_W-1:0];
            CFG_DEG_HIGH: deg_hi_r = data[DEG_W-1:0];
            CFG_PLS_LOW:  pls_lo_r = data[PULSE_W-1:0];
            CFG_PLS_HIGH: pls_hi_r = data[PULSE_W-1:0];
            CFG_STEP:     step_r = data[PULSE_W-1:0];
            CFG_HOME_DEG: home_deg_r = data[DEG_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(int dl, int dh, int pl, int ph, int st, int hd);
        wait_idle();
        cfg_write(CFG_DEG_LOW, CFG_DAT_W'(dl));
        cfg_write(CFG_DEG_HIGH, CFG_DAT_W'(dh));
        cfg_write(CFG_PLS_LOW, CFG_DAT_W'(pl));
        cfg_write(CFG_PLS_HIGH, CFG_DAT_W'(ph));
        cfg_write(CFG_STEP, CFG_DAT_W'(st));
        cfg_write(CFG_HOME_DEG, CFG_DAT_W'(hd));
    endtask

    task automatic queue_random(int n);
        for (int k = 0; k < n; k++) pending_cmds.push_back(random_cmd());
    endtask

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // sender: bursts of transfers separated by idle gaps of random length, possibly none
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_cmds.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (pending_cmds[0].drain && (i_in_valid || pending_widths.size() != 0)) begin
                i_in_valid <= 1'b0;
            end else begin
                drv_cmd = pending_cmds.pop_front();
                i_req_type  <= drv_cmd.req;
                i_angle     <= drv_cmd.angle;
                i_direction <= drv_cmd.dir;
                i_in_valid  <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                             : $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 60);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 1) == 1);
            default: i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                seen_cmd.req   = i_req_type;
                seen_cmd.angle = i_angle;
                seen_cmd.dir   = i_direction;
                seen_cmd.drain = 1'b0;
                pending_widths.push_back(step_servo(seen_cmd));
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_widths.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errors++;
                end else begin
                    want = pending_widths.pop_front();
                    if (o_pulse_width !== want.pulse) begin
                        $error("pulse_width expected %0d got %0d", want.pulse, o_pulse_width);
                        errors++;
                    end
                    if (o_target_width !== want.target) begin
                        $error("target_width expected %0d got %0d", want.target, o_target_width);
                        errors++;
                    end
                    if (o_pwm_write !== want.pwm) begin
                        $error("pwm_write expected %0d got %0d", want.pwm, o_pwm_write);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        reset_servo_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // tick with nothing to move, range ends, every request kind
        pending_cmds.push_back(make_cmd(REQ_TICK, 0, DIR_HOLD));
        pending_cmds.push_back(make_cmd(REQ_ABS, ANGLE_MAX, DIR_HOLD));
        pending_cmds.push_back(make_cmd(REQ_TICK, 0, DIR_HOLD));
        pending_cmds.push_back(make_cmd(REQ_TICK, 0, DIR_HOLD));
        pending_cmds.push_back(make_cmd(REQ_ABS, -ANGLE_MAX, DIR_HOLD));
        pending_cmds.push_back(make_cmd(REQ_ABS, 0, DIR_HOLD));
        pending_cmds.push_back(make_cmd(REQ_ABS, 1447, DIR_HOLD));
        pending_cmds.push_back(make_cmd(REQ_REL, ANGLE_MAX, DIR_HOLD));
        pending_cmds.push_back(make_cmd(REQ_REL, -ANGLE_MAX, DIR_HOLD));
        pending_cmds.push_back(make_cmd(REQ_REL, -1, DIR_HOLD));
        pending_cmds.push_back(make_cmd(REQ_REL, 1, DIR_HOLD));
        pending_cmds.push_back(make_cmd(REQ_ROTATE, 0, DIR_UP));
        pending_cmds.push_back(make_cmd(REQ_TICK, 0, DIR_HOLD));
        pending_cmds.push_back(make_cmd(REQ_ROTATE, 0, DIR_DOWN));
        pending_cmds.push_back(make_cmd(REQ_TICK, 0, DIR_HOLD));
        pending_cmds.push_back(make_cmd(REQ_ROTATE, 0, DIR_HOLD));
        pending_cmds.push_back(make_cmd(REQ_ROTATE, 0, DIR_FAR_DOWN));
        pending_cmds.push_back(make_cmd(REQ_STOP, 0, DIR_HOLD));
        pending_cmds.push_back(make_cmd(REQ_HOME, 0, DIR_HOLD));
        pending_cmds.push_back(make_cmd(REQ_TICK, 0, DIR_HOLD));
        pending_cmds.push_back(make_cmd(REQ_SPARE_A, -ANGLE_MAX, DIR_UP));
        pending_cmds.push_back(make_cmd(REQ_SPARE_B, ANGLE_MAX, DIR_FAR_DOWN));
        pending_cmds.push_back(make_cmd(REQ_TICK, 0, DIR_HOLD));
        queue_random(120);

        // full pulse range, degrees -360 to 360, biggest step
        apply_setting(-360, 360, 0, 4095, 4095, 0);
        queue_random(130);
        // reversed pulse bounds, zero step
        apply_setting(-360, 360, 4095, 0, 0, -360);
        queue_random(130);
        // equal degree bounds
        apply_setting(100, 100, 150, 600, 7, 100);
        queue_random(130);
        // reversed degree bounds
        apply_setting(180, 0, 150, 600, 9, 45);
        queue_random(130);
        // narrow span drives target into saturation
        apply_setting(0, 1, 0, 4095, 1, 1);
        queue_random(130);
        apply_setting(360, -360, 200, 2500, 64, 360);
        queue_random(130);
        for (int p = 0; p < 5; p++) begin
            apply_setting(int'($urandom_range(0, 720)) - 360, int'($urandom_range(0, 720)) - 360,
                          $urandom_range(0, 4095), $urandom_range(0, 4095),
                          ($urandom_range(0, 1) == 1) ? $urandom_range(0, 4095)
                                                      : $urandom_range(0, 40),
                          int'($urandom_range(0, 720)) - 360);
            queue_random(130);
        end

        wait_idle();
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
